// ===== hw/rtl/mcr_pkg.sv =====
package mcr_pkg;

  // Field widths
  localparam int unsigned CoordW = 8;
  localparam int unsigned ColorW = 16;
  localparam int unsigned PixW   = 10;
  localparam int unsigned StepXW = 9;
  localparam int unsigned StepYW = 10;
  localparam int unsigned ErrW   = 13;

  // Stream data widths, padded to whole bytes
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 40;

  // Configuration port
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgAddrW-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_RADIUS   = 2'd2,
    REG_COLOR    = 2'd3
  } cfg_reg_t;

endpackage

// ===== hw/rtl/midpoint_circle_rasterizer.sv =====
// Midpoint circle rasterizer.
// Configure center_x, center_y, radius and color through the cfg_ write
// port while the block is idle. Each transfer on the in_ channel advances
// the circle by one step; in_tdata[0] set reloads the loop from the
// configuration before stepping. A step of an active circle yields eight
// mirrored points on the out_ channel, out_tlast marking the eighth and
// out_tuser set on all eight when the step finished the circle. Steps
// with no circle in progress are taken and yield nothing.
// A step's points pass from the step register, which loads at the input
// transfer, to the output register, which loads one point per cycle while
// it is empty or its point is taken; the next input is taken in the cycle
// the eighth point moves to the output register, so while the receiver is
// ready and inputs wait, points stream with no gaps.
// When the receiver stalls, the output register holds its point and the
// input side stops once the current step's points are queued.
// Reset (rst_n low, synchronous) clears the configuration, the loop state
// and both valid flags; no circle is in progress afterwards.
module midpoint_circle_rasterizer (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [mcr_pkg::CfgAddrW-1:0]       cfg_addr,
  input  logic [mcr_pkg::CfgDataW-1:0]       cfg_wdata,
  // step requests
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [mcr_pkg::InDataW-1:0]        in_tdata,   // [0] restart
  // points
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mcr_pkg::OutDataW-1:0]       out_tdata,  // [9:0] pixel_x, [19:10] pixel_y,
                                                         // [35:20] pixel_color
  output logic                               out_tlast,
  output logic                               out_tuser   // [0] circle_done
);

  localparam int unsigned CW = mcr_pkg::CoordW;
  localparam int unsigned XW = mcr_pkg::StepXW;
  localparam int unsigned YW = mcr_pkg::StepYW;
  localparam int unsigned EW = mcr_pkg::ErrW;
  localparam int unsigned PW = mcr_pkg::PixW;

  // configuration registers
  logic [CW-1:0]             center_x_r, center_y_r, radius_r;
  logic [mcr_pkg::ColorW-1:0] color_r;

  // loop state
  logic [XW-1:0] step_x_r, step_x_nxt;
  logic [YW-1:0] step_y_r, step_y_nxt;
  logic [EW-1:0] err_r, err_nxt;
  logic          active_r, active_nxt;

  // step register: one step's points waiting to be sent
  logic          busy_r, busy_nxt;
  logic [2:0]    idx_r, idx_nxt;
  logic [XW-1:0] bx_r, bx_nxt;
  logic [YW-1:0] by_r, by_nxt;
  logic          bdone_r, bdone_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [PW-1:0] px_r, px_nxt, py_r, py_nxt;
  logic [mcr_pkg::ColorW-1:0] pcol_r;
  logic          plast_r, pdone_r;

  // step computation
  logic                 in_fire, restart, run, emit;
  logic [XW-1:0]        x0;
  logic [YW-1:0]        y0;
  logic [EW-1:0]        e0, e_neg_sum, e_pos_sum, diff4;
  logic [EW-1:0]        diff;
  logic signed [YW:0]   y_new, x_inc;
  logic                 done;
  logic                 out_load, burst_end;

  // point generation
  logic [YW-1:0]  a_val, b_val;
  logic [PW:0]    px_sum, py_sum;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      radius_r   <= '0;
      color_r    <= '0;
    end else if (cfg_we) begin
      unique case (mcr_pkg::cfg_reg_t'(cfg_addr))
        mcr_pkg::REG_CENTER_X: center_x_r <= cfg_wdata[CW-1:0];
        mcr_pkg::REG_CENTER_Y: center_y_r <= cfg_wdata[CW-1:0];
        mcr_pkg::REG_RADIUS:   radius_r   <= cfg_wdata[CW-1:0];
        mcr_pkg::REG_COLOR:    color_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // handshake
  assign out_load  = busy_r && (!out_valid_r || out_tready);
  assign burst_end = out_load && (idx_r == 3'd7);
  assign in_tready = !busy_r || burst_end;
  assign in_fire   = in_tvalid && in_tready;
  assign restart   = in_tdata[0];

  // one loop step of the midpoint algorithm
  always_comb begin
    x0   = restart ? '0 : step_x_r;
    y0   = restart ? {{(YW-CW){1'b0}}, radius_r} : step_y_r;
    e0   = restart ? (EW'(2) - {{(EW-CW-1){1'b0}}, radius_r, 1'b0}) : err_r;
    run  = restart || active_r;
    emit = run && ({1'b0, x0} <= y0);

    e_neg_sum = e0 + {{(EW-XW-2){1'b0}}, x0, 2'b00} + EW'(6);
    diff      = {{(EW-XW){1'b0}}, x0} - {{(EW-YW){1'b0}}, y0};
    diff4     = {diff[EW-3:0], 2'b00};
    e_pos_sum = e0 + diff4 + EW'(10);

    y_new = e0[EW-1] ? $signed({1'b0, y0}) : ($signed({1'b0, y0}) - (YW+1)'(1));
    x_inc = $signed({2'b00, x0} + (YW+1)'(1));
    done  = x_inc > y_new;

    step_x_nxt = step_x_r;
    step_y_nxt = step_y_r;
    err_nxt    = err_r;
    active_nxt = active_r;
    if (in_fire) begin
      if (restart) begin
        step_x_nxt = x0;
        step_y_nxt = y0;
        err_nxt    = e0;
        active_nxt = 1'b1;
      end
      if (emit) begin
        step_x_nxt = x_inc[XW-1:0];
        step_y_nxt = y_new[YW-1:0];
        err_nxt    = e0[EW-1] ? e_neg_sum : e_pos_sum;
        active_nxt = !done;
      end else if (run) begin
        active_nxt = 1'b0;
      end
    end
  end

  // step register sequencing
  always_comb begin
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    bx_nxt    = bx_r;
    by_nxt    = by_r;
    bdone_nxt = bdone_r;
    if (out_load) begin
      idx_nxt = idx_r + 3'd1;
      if (burst_end) begin
        busy_nxt = 1'b0;
      end
    end
    if (in_fire && emit) begin
      busy_nxt  = 1'b1;
      idx_nxt   = '0;
      bx_nxt    = x0;
      by_nxt    = y0;
      bdone_nxt = done;
    end
  end

  // mirrored point for the current index
  always_comb begin
    a_val  = idx_r[2] ? by_r : {{(YW-XW){1'b0}}, bx_r};
    b_val  = idx_r[2] ? {{(YW-XW){1'b0}}, bx_r} : by_r;
    px_sum = idx_r[1] ? ({{(PW+1-CW){1'b0}}, center_x_r} - {1'b0, a_val})
                      : ({{(PW+1-CW){1'b0}}, center_x_r} + {1'b0, a_val});
    py_sum = idx_r[0] ? ({{(PW+1-CW){1'b0}}, center_y_r} - {1'b0, b_val})
                      : ({{(PW+1-CW){1'b0}}, center_y_r} + {1'b0, b_val});
    px_nxt = px_sum[PW-1:0];
    py_nxt = py_sum[PW-1:0];
    out_valid_nxt = out_load || (out_valid_r && !out_tready);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_x_r    <= '0;
      step_y_r    <= '0;
      err_r       <= '0;
      active_r    <= 1'b0;
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_x_r    <= step_x_nxt;
      step_y_r    <= step_y_nxt;
      err_r       <= err_nxt;
      active_r    <= active_nxt;
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    bx_r    <= bx_nxt;
    by_r    <= by_nxt;
    bdone_r <= bdone_nxt;
    if (out_load) begin
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      pcol_r  <= color_r;
      plast_r <= (idx_r == 3'd7);
      pdone_r <= bdone_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(mcr_pkg::OutDataW - 2*PW - mcr_pkg::ColorW){1'b0}},
                       pcol_r, py_r, px_r};
  assign out_tlast  = plast_r;
  assign out_tuser  = pdone_r;

endmodule

// ===== hw/rtl/mcr_checker.sv =====
module mcr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [mcr_pkg::OutDataW-1:0]  out_tdata,
  input logic                          out_tlast,
  input logic                          out_tuser
);

  // a stalled point holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled point changed");

  // nothing is presented right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // a step has eight points, so two last markers never come back to back
  a_last_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !(out_tvalid && out_tlast))
    else $error("last marker repeated");

  // circle_done stays the same from one point to the next within a step
  a_done_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast ##1 out_tvalid
      |-> out_tuser == $past(out_tuser))
    else $error("circle_done changed inside a step");

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// ===== verif/circle_checker.sv =====
module circle_checker
  import mcr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // [0] restart
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OutDataW-1:0] out_tdata,  // [9:0] pixel_x, [19:10] pixel_y, [35:20] pixel_color
  input  logic                out_tlast,
  input  logic                out_tuser,  // [0] circle_done
  output int                  pending,
  output int                  fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxReports = 40;

  typedef struct packed {
    logic [PixW-1:0]   px;
    logic [PixW-1:0]   py;
    logic [ColorW-1:0] color;
    logic              last;
    logic              done;
  } point_t;

  // shadow of the configuration registers
  logic [CoordW-1:0] ctr_x, ctr_y, rad;
  logic [ColorW-1:0] paint;

  // shadow of the loop state
  logic [StepXW-1:0]      loop_x;
  logic [StepYW-1:0]      loop_y;
  logic signed [ErrW-1:0] loop_err;
  logic                   tracing;

  point_t expected_points[$];
  int     mismatches = 0;

  assign fail_count = mismatches;

  function automatic void note_mismatch(string field, int expv, int gotv);
    mismatches++;
    if (mismatches <= MaxReports)
      $error("%s mismatch: expected %0d, got %0d", field, expv, gotv);
  endfunction

  function automatic void queue_point(int px, int py, logic lst, logic fin);
    point_t p;
    p.px    = px[PixW-1:0];
    p.py    = py[PixW-1:0];
    p.color = paint;
    p.last  = lst;
    p.done  = fin;
    expected_points.push_back(p);
  endfunction

  // one loop step of the midpoint circle; queues the eight mirrored points when a circle is in progress
  function automatic void advance_circle(logic restart);
    int   x, y, yv, e, cx, cy;
    logic fin;
    if (restart) begin
      loop_x   = '0;
      loop_y   = StepYW'(rad);
      loop_err = ErrW'(2 - 2 * int'(rad));
      tracing  = 1'b1;
    end
    if (!tracing) return;
    x  = int'(loop_x);
    y  = int'(loop_y);
    yv = y;
    if (x > y) begin
      tracing = 1'b0;
      return;
    end
    cx = int'(ctr_x);
    cy = int'(ctr_y);
    e  = int'(loop_err);
    if (e < 0) begin
      e += 4 * x + 6;
    end else begin
      e += 4 * (x - y) + 10;
      y -= 1;
    end
    fin = (x + 1) > y;
    queue_point(cx + x,  cy + yv, 1'b0, fin);
    queue_point(cx + x,  cy - yv, 1'b0, fin);
    queue_point(cx - x,  cy + yv, 1'b0, fin);
    queue_point(cx - x,  cy - yv, 1'b0, fin);
    queue_point(cx + yv, cy + x,  1'b0, fin);
    queue_point(cx + yv, cy - x,  1'b0, fin);
    queue_point(cx - yv, cy + x,  1'b0, fin);
    queue_point(cx - yv, cy - x,  1'b1, fin);
    loop_err = e[ErrW-1:0];
    loop_y   = y[StepYW-1:0];
    loop_x   = StepXW'(x + 1);
    if (fin) tracing = 1'b0;
  endfunction

  always @(posedge clk) begin
    point_t got, want;
    if (!rst_n) begin
      ctr_x    = '0;
      ctr_y    = '0;
      rad      = '0;
      paint    = '0;
      loop_x   = '0;
      loop_y   = '0;
      loop_err = '0;
      tracing  = 1'b0;
      expected_points.delete();
    end else begin
      // result side: compare against the oldest expected point
      if (out_tvalid && out_tready) begin
        got.px    = out_tdata[PixW-1:0];
        got.py    = out_tdata[2*PixW-1:PixW];
        got.color = out_tdata[2*PixW+ColorW-1:2*PixW];
        got.last  = out_tlast;
        got.done  = out_tuser;
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $error("point (%0d,%0d) transferred with none expected",
                   $signed(got.px), $signed(got.py));
        end else begin
          want = expected_points.pop_front();
          if (got.px !== want.px)
            note_mismatch("pixel_x", int'($signed(want.px)), int'($signed(got.px)));
          if (got.py !== want.py)
            note_mismatch("pixel_y", int'($signed(want.py)), int'($signed(got.py)));
          if (got.color !== want.color)
            note_mismatch("pixel_color", int'(want.color), int'(got.color));
          if (got.last !== want.last)
            note_mismatch("last", int'(want.last), int'(got.last));
          if (got.done !== want.done)
            note_mismatch("circle_done", int'(want.done), int'(got.done));
        end
      end
      // register writes
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_CENTER_X: ctr_x = cfg_wdata[CoordW-1:0];
          REG_CENTER_Y: ctr_y = cfg_wdata[CoordW-1:0];
          REG_RADIUS:   rad   = cfg_wdata[CoordW-1:0];
          REG_COLOR:    paint = cfg_wdata[ColorW-1:0];
          default: ;
        endcase
      end
      // step request side
      if (in_tvalid && in_tready) advance_circle(in_tdata[0]);
    end
    pending <= expected_points.size();
  end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mcr_pkg::*;

  localparam int StepTarget = 310;
  localparam int DrainCycles = 16;
  localparam int Watchdog = 3000;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;   // [0] restart
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;  // [9:0] pixel_x, [19:10] pixel_y, [35:20] pixel_color
  logic                out_tlast;
  logic                out_tuser;  // [0] circle_done

  int pending;
  int fail_count;
  int steps_sent = 0;
  int quiet = 0;
  bit calm = 1'b0;

  midpoint_circle_rasterizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  circle_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .pending   (pending),
    .fail_count(fail_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= Watchdog) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver back-pressure: short stalls mostly, a few long, some long ready runs
  initial begin
    int run;
    int r;
    out_tready = 1'b0;
    run = 0;
    forever begin
      @(negedge clk);
      if (run > 0) begin
        run--;
      end else if (out_tready) begin
        r = $urandom_range(0, 99);
        out_tready = 1'b0;
        if (r < 70) run = $urandom_range(0, 1);
        else if (r < 92) run = $urandom_range(2, 7);
        else run = $urandom_range(20, 40);
      end else begin
        r = $urandom_range(0, 99);
        out_tready = 1'b1;
        if (r < 80) run = $urandom_range(0, 10);
        else run = $urandom_range(40, 200);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CfgDataW-1:0] pick_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return CfgDataW'(8'hFF);
    return CfgDataW'($urandom_range(0, 255));
  endfunction

  function automatic logic [CfgDataW-1:0] pick_radius();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 70) return CfgDataW'($urandom_range(1, 12));
    if (r < 88) return CfgDataW'($urandom_range(13, 40));
    if (r < 96) return CfgDataW'($urandom_range(41, 254));
    return CfgDataW'(8'hFF);
  endfunction

  task automatic set_reg(cfg_reg_t idx, logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // one step request transfer, after a random gap
  task automatic send_step(logic restart);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = InDataW'(restart);
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    steps_sent++;
  endtask

  // drop valid, let all expected points drain, then give the block time to go idle
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    int n;
    bit noise;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_CENTER_X;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // nothing started since reset: step yields no points
    send_step(1'b0);

    // zero radius at the origin, then a step on the finished circle
    settle();
    set_reg(REG_COLOR, '0);
    send_step(1'b1);
    send_step(1'b0);

    // largest center and radius, then radius 255 at the origin (negative coords)
    settle();
    set_reg(REG_CENTER_X, 16'h00FF);
    set_reg(REG_CENTER_Y, 16'h00FF);
    set_reg(REG_RADIUS, 16'h00FF);
    set_reg(REG_COLOR, 16'hFFFF);
    send_step(1'b1);
    send_step(1'b0);
    send_step(1'b0);
    settle();
    set_reg(REG_CENTER_X, '0);
    set_reg(REG_CENTER_Y, '0);
    set_reg(REG_COLOR, 16'h5A5A);
    send_step(1'b1);
    send_step(1'b0);

    // small circle run to completion and two steps past it
    settle();
    set_reg(REG_RADIUS, 16'd3);
    set_reg(REG_CENTER_X, 16'h0080);
    set_reg(REG_CENTER_Y, 16'h0040);
    send_step(1'b1);
    repeat (4) send_step(1'b0);

    // restart in the middle of a circle
    settle();
    set_reg(REG_RADIUS, 16'd10);
    send_step(1'b1);
    send_step(1'b0);
    send_step(1'b1);
    send_step(1'b0);

    // new center/color apply at once, new radius only after a restart
    settle();
    set_reg(REG_CENTER_X, 16'h0010);
    set_reg(REG_CENTER_Y, 16'h00F0);
    set_reg(REG_COLOR, 16'h1234);
    set_reg(REG_RADIUS, 16'd2);
    send_step(1'b0);
    send_step(1'b0);
    send_step(1'b1);
    send_step(1'b0);

    // random phases: new settings, then steps, usually a restart first and plain steps after
    while (steps_sent < StepTarget) begin
      settle();
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 60) set_reg(REG_CENTER_X, pick_coord());
      if ($urandom_range(0, 99) < 60) set_reg(REG_CENTER_Y, pick_coord());
      if ($urandom_range(0, 99) < 70) set_reg(REG_RADIUS, pick_radius());
      if ($urandom_range(0, 99) < 50) set_reg(REG_COLOR, CfgDataW'($urandom_range(0, 65535)));
      n     = $urandom_range(4, 24);
      noise = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < n; i++) begin
        if (i == 0) send_step(!noise);
        else send_step($urandom_range(0, 99) < 6);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mcr_pkg.sv
hw/rtl/midpoint_circle_rasterizer.sv
hw/rtl/mcr_checker.sv
verif/circle_checker.sv
verif/tb_top.sv
